// File: hdl/ssra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step-rate accumulator package
// Item and result types, register indexes, reset values and fixed widths.
// ----------------------------------------------------------------------------
package ssra_pkg;

  localparam int SPEED_W     = 32;
  localparam int TIME_W      = 24;
  localparam int STEPS_W     = 18;
  localparam int TOTAL_W     = 32;
  localparam int RATE_W      = 32;
  localparam int RATE_FRAC_W = 16;
  localparam int DEADBAND_W  = 31;
  localparam int CFG_W       = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int MUL_W       = 32;
  localparam int DIGIT_W     = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_RAD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE  = 2'd2;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET  = 31'd655;
  localparam logic [MUL_W-1:0]      STEPS_RAD_RESET = 32'd2086059;
  localparam logic [RATE_W-1:0]     MAX_RATE_RESET  = 32'd655360000;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [SPEED_W-1:0] wheel_speed;
    logic [TIME_W-1:0]         elapsed_time;
  } item_t;

  typedef struct packed {
    logic signed [STEPS_W-1:0] steps_now;
    logic signed [TOTAL_W-1:0] total_steps;
    logic [RATE_W-1:0]         step_rate;
    logic                      forward;
    logic                      rate_clamped;
  } result_t;

endpackage

// File: hdl/ssra_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Unsigned MUL_W x MUL_W product, one DIGIT_W-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module ssra_serial_mul import ssra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic                 done,
  output logic [2*MUL_W-1:0]   product
);

  localparam int DIGITS = MUL_W / DIGIT_W;
  localparam int CNT_W  = $clog2(DIGITS);
  localparam int PART_W = MUL_W + DIGIT_W;

  logic [MUL_W-1:0]  hi;
  logic [MUL_W-1:0]  lo;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic [PART_W-1:0] partial;

  assign partial = {{DIGIT_W{1'b0}}, hi}
                 + (PART_W'(a) * PART_W'(lo[DIGIT_W-1:0]));
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hi    <= '0;
        lo    <= b;
        count <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        hi    <= partial[PART_W-1:DIGIT_W];
        lo    <= {partial[DIGIT_W-1:0], lo[MUL_W-1:DIGIT_W]};
        count <= count + 1'b1;
        if (count == CNT_W'(DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/stepper_step_rate_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper step-rate accumulator
// Turns a signed wheel speed and elapsed time into whole steps per tick.
// ----------------------------------------------------------------------------
// Items enter on item_valid / item_stall and results leave on result_valid /
// result_stall; a transfer happens on an edge with valid high and stall low.
// Each tick item scales |wheel_speed| by steps_per_radian, applies deadband
// and max_step_rate, multiplies the rate by elapsed_time and folds it into a
// signed fractional remainder; whole steps go out and into the wrapping total.
// A clear item zeroes remainder and total and returns an all-zero result.
// Both products run in turn on one 4-bit digit-serial multiplier; the time
// product is skipped when the rate or the time is zero, and a clear item
// goes straight to its result without either product.
// One item is in work at a time; item_stall is high from acceptance until its
// result is loaded, and the next item can be taken in the cycle after that.
// The result register lets the next item be accepted while a result waits;
// if the receiver still stalls when the next result is ready, the block
// holds that result and keeps item_stall high.
// Configuration writes on cfg_write take effect at once; write only when idle.
// Reset restores default registers, clears remainder, total and result_valid.
// ----------------------------------------------------------------------------
module stepper_step_rate_accumulator_core import ssra_pkg::*; #(
  parameter int REMAINDER_FRAC_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int PROD_SHIFT = RATE_FRAC_W + TIME_W - REMAINDER_FRAC_BITS;
  localparam int INC_W      = RATE_W + TIME_W - PROD_SHIFT;
  localparam int SUM_W      = INC_W + 2;
  localparam int REM_W      = REMAINDER_FRAC_BITS + 1;
  localparam int SCALED_W   = 2 * MUL_W - RATE_FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_SCALE,
    S_SCALE,
    S_MUL_TIME,
    S_ACCUM,
    S_SPLIT,
    S_DONE
  } state_t;

  state_t state;

  logic [DEADBAND_W-1:0] deadband_speed;
  logic [MUL_W-1:0]      steps_per_radian;
  logic [RATE_W-1:0]     max_step_rate;

  logic                      fwd;
  logic [MUL_W-1:0]          mag;
  logic [TIME_W-1:0]         dt;
  logic [RATE_W-1:0]         rate;
  logic                      clamped;
  logic signed [STEPS_W-1:0] steps;
  logic signed [SUM_W-1:0]   sum;
  logic signed [REM_W-1:0]   remainder;
  logic [TOTAL_W-1:0]        total;

  logic                 mul_start;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic                 mul_done;
  logic [2*MUL_W-1:0]   mul_product;

  logic [SPEED_W-1:0]      speed_bits;
  logic [MUL_W-1:0]        mag_in;
  logic [SCALED_W-1:0]     scaled;
  logic [RATE_W-1:0]       rate_calc;
  logic                    clamp_calc;
  logic [INC_W-1:0]        inc_mag;
  logic signed [SUM_W-1:0] rem_ext;
  logic signed [SUM_W-1:0] inc_ext;
  logic signed [SUM_W-1:0] sum_calc;
  logic [SUM_W-1:0]        sum_abs;
  logic [STEPS_W-1:0]      whole_mag;
  logic [REM_W-1:0]        frac_ext;
  logic signed [STEPS_W-1:0] whole;
  logic signed [REM_W-1:0]   rem_calc;

  ssra_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  assign item_stall = (state != S_IDLE);

  always_comb begin
    speed_bits = item.wheel_speed;
    mag_in     = speed_bits[SPEED_W-1] ? (~speed_bits + 32'd1) : speed_bits;

    scaled = mul_product[2*MUL_W-1:RATE_FRAC_W];
    if (mag < {1'b0, deadband_speed}) begin
      rate_calc  = '0;
      clamp_calc = 1'b0;
    end else if (scaled > SCALED_W'(max_step_rate)) begin
      rate_calc  = max_step_rate;
      clamp_calc = 1'b1;
    end else begin
      rate_calc  = scaled[RATE_W-1:0];
      clamp_calc = 1'b0;
    end

    inc_mag  = mul_product[RATE_W+TIME_W-1:PROD_SHIFT];
    rem_ext  = {{(SUM_W-REM_W){remainder[REM_W-1]}}, remainder};
    inc_ext  = {2'b00, inc_mag};
    sum_calc = fwd ? (rem_ext + inc_ext) : (rem_ext - inc_ext);

    sum_abs   = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    whole_mag = sum_abs[SUM_W-1:REMAINDER_FRAC_BITS];
    frac_ext  = {1'b0, sum_abs[REMAINDER_FRAC_BITS-1:0]};
    whole     = sum[SUM_W-1] ? -$signed(whole_mag) : $signed(whole_mag);
    rem_calc  = sum[SUM_W-1] ? -$signed(frac_ext) : $signed(frac_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_speed   <= DEADBAND_RESET;
      steps_per_radian <= STEPS_RAD_RESET;
      max_step_rate    <= MAX_RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEADBAND:  deadband_speed   <= cfg_data[DEADBAND_W-1:0];
        REG_STEPS_RAD: steps_per_radian <= cfg_data;
        REG_MAX_RATE:  max_step_rate    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      mul_start    <= 1'b0;
      remainder    <= '0;
      total        <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.func == FUNC_CLEAR) begin
              remainder <= '0;
              total     <= '0;
              steps     <= '0;
              rate      <= '0;
              clamped   <= 1'b0;
              fwd       <= 1'b0;
              state     <= S_DONE;
            end else begin
              fwd       <= ~speed_bits[SPEED_W-1];
              mag       <= mag_in;
              dt        <= item.elapsed_time;
              mul_a     <= mag_in;
              mul_b     <= steps_per_radian;
              mul_start <= 1'b1;
              state     <= S_MUL_SCALE;
            end
          end
        end
        S_MUL_SCALE: begin
          mul_start <= 1'b0;
          if (mul_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          rate    <= rate_calc;
          clamped <= clamp_calc;
          steps   <= '0;
          if (rate_calc == '0 || dt == '0) begin
            state <= S_DONE;
          end else begin
            mul_a     <= rate_calc;
            mul_b     <= MUL_W'(dt);
            mul_start <= 1'b1;
            state     <= S_MUL_TIME;
          end
        end
        S_MUL_TIME: begin
          mul_start <= 1'b0;
          if (mul_done) begin
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          sum   <= sum_calc;
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          remainder <= rem_calc;
          total     <= total + {{(TOTAL_W-STEPS_W){whole[STEPS_W-1]}}, whole};
          steps     <= whole;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid        <= 1'b1;
            result.steps_now    <= steps;
            result.total_steps  <= total;
            result.step_rate    <= rate;
            result.forward      <= fwd;
            result.rate_clamped <= clamped;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/ssra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step-rate accumulator checker
// Port-level properties of the step-rate accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module ssra_checker import ssra_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted without going busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result dropped or changed");

  a_zero_rate_no_steps: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.step_rate == '0 |-> result.steps_now == '0)
    else $error("steps issued at zero rate");

  a_forward_nonnegative: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.forward |-> !result.steps_now[STEPS_W-1])
    else $error("negative steps on forward tick");

endmodule

bind stepper_step_rate_accumulator_core ssra_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// File: dv/stepper_step_rate_accumulator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step-rate accumulator testbench
// Drives ticks and clears through the item channel with bursty sending and
// patterned result stalls, predicts steps, total, rate and flags per item
// from a fixed-point model of the remainder and total, and compares every
// result field against the oldest prediction under several register settings.
// ----------------------------------------------------------------------------
module stepper_step_rate_accumulator_core_tb;
  import ssra_pkg::*;

  localparam int REM_FRAC       = 24;
  localparam int INC_SHIFT      = RATE_FRAC_W + TIME_W - REM_FRAC;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 180;

  typedef enum int {RX_FREE, RX_COIN, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  class step_scoreboard;
    logic [DEADBAND_W-1:0] deadband;
    logic [MUL_W-1:0]      rad_scale;
    logic [RATE_W-1:0]     max_rate;
    longint                remainder;
    logic [TOTAL_W-1:0]    total;
    result_t               expected_q[$];
    int mismatches, n_ticks, n_clears, n_clamped, n_stepped;

    function new();
      deadband      = DEADBAND_RESET;
      rad_scale     = STEPS_RAD_RESET;
      max_rate      = MAX_RATE_RESET;
      remainder     = 0;
      total         = '0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DEADBAND:  deadband = data[DEADBAND_W-1:0];
        REG_STEPS_RAD: rad_scale = data[MUL_W-1:0];
        REG_MAX_RATE:  max_rate = data[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      result_t           want;
      logic              fwd;
      logic [SPEED_W-1:0] mag;
      logic [63:0]       prod;
      logic [63:0]       inc;
      longint            whole;
      want = '0;
      if (it.func == FUNC_CLEAR) begin
        remainder = 0;
        total = '0;
        n_clears++;
        expected_q.push_back(want);
        return;
      end
      n_ticks++;
      fwd = ~it.wheel_speed[SPEED_W-1];
      mag = fwd ? it.wheel_speed : -it.wheel_speed;
      want.forward = fwd;
      if (mag >= {1'b0, deadband}) begin
        prod = (64'(mag) * 64'(rad_scale)) >> RATE_FRAC_W;
        if (prod > 64'(max_rate)) begin
          prod = 64'(max_rate);
          want.rate_clamped = 1'b1;
          n_clamped++;
        end
        want.step_rate = prod[RATE_W-1:0];
      end
      if (it.elapsed_time != '0 && want.step_rate != '0) begin
        inc = (64'(want.step_rate) * 64'(it.elapsed_time)) >> INC_SHIFT;
        remainder += fwd ? longint'(inc) : -longint'(inc);
        whole = (remainder < 0) ? -((-remainder) >> REM_FRAC) : (remainder >> REM_FRAC);
        remainder -= whole * (longint'(1) << REM_FRAC);
        total += whole[TOTAL_W-1:0];
        want.steps_now = whole[STEPS_W-1:0];
        if (whole != 0) n_stepped++;
      end
      want.total_steps = total;
      expected_q.push_back(want);
    endfunction

    function string show(result_t r);
      return $sformatf("steps=%0d total=%0d rate=%h fwd=%b clamp=%b",
                       r.steps_now, r.total_steps, r.step_rate, r.forward,
                       r.rate_clamped);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.steps_now !== want.steps_now || got.total_steps !== want.total_steps ||
          got.step_rate !== want.step_rate || got.forward !== want.forward ||
          got.rate_clamped !== want.rate_clamped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected %s, got %s", $realtime, show(want),
                   show(got));
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  step_scoreboard sb = new();
  int       burst_left = 0;
  int       quiet = 0;
  int       n_settings = 1;
  int       stall_left = 0;
  rx_mode_e rx_mode = RX_FREE;

  stepper_step_rate_accumulator_core #(.REMAINDER_FRAC_BITS(REM_FRAC)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (rx_mode)
      RX_FREE:     result_stall <= 1'b0;
      RX_COIN:     result_stall <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: result_stall <= (stall_left % 5 < 2);
      default:     result_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", quiet);
        $display("stepper_step_rate_accumulator_core_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 9) < 3) gap = 0;
      else if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
      else gap = $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic tick(input logic [SPEED_W-1:0] speed, input logic [TIME_W-1:0] dt);
    item_t it;
    it.func = FUNC_TICK;
    it.wheel_speed = speed;
    it.elapsed_time = dt;
    send(it);
  endtask

  task automatic clear_state();
    item_t it;
    it.func = FUNC_CLEAR;
    it.wheel_speed = $urandom();
    it.elapsed_time = TIME_W'($urandom());
    send(it);
  endtask

  // hold off new items until every result is back
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic item_t random_item();
    item_t              it;
    int                 pick;
    logic [SPEED_W-1:0] mag;
    it.func = ($urandom_range(0, 24) == 0) ? FUNC_CLEAR : FUNC_TICK;
    pick = $urandom_range(0, 99);
    if (pick < 35) mag = $urandom();
    else if (pick < 65) mag = $urandom_range(0, 32'h0200_0000);
    else if (pick < 80) mag = {1'b0, sb.deadband} + $urandom_range(0, 4) - 2;
    else begin
      case ($urandom_range(0, 5))
        0: mag = 32'h0000_0000;
        1: mag = 32'h0000_0001;
        2: mag = 32'hFFFF_FFFF;
        3: mag = 32'h7FFF_FFFF;
        4: mag = 32'h8000_0000;
        default: mag = 32'h8000_0001;
      endcase
    end
    it.wheel_speed = ($urandom_range(0, 1) == 1) ? -mag : mag;
    pick = $urandom_range(0, 99);
    if (pick < 8) it.elapsed_time = '0;
    else if (pick < 16) it.elapsed_time = '1;
    else if (pick < 50) it.elapsed_time = TIME_W'($urandom());
    else it.elapsed_time = TIME_W'($urandom_range(1, 65535));
    return it;
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] spr,
                           input logic [CFG_W-1:0] mr);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_STEPS_RAD, spr);
    write_reg(REG_MAX_RATE, mr);
    n_settings++;
    repeat (PHASE_ITEMS) begin
      send(random_item());
      if ($urandom_range(0, 149) == 0) settle();
    end
    settle();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default registers: deadband edges, extremes, zero time and rate, clears
    tick(32'h0000_0000, 24'hFF_FFFF);
    tick(32'd654, 24'hFF_FFFF);
    tick(32'd655, 24'hFF_FFFF);
    tick(-32'd655, 24'hFF_FFFF);
    tick(32'hFFFF_FFFF, 24'hFF_FFFF);
    tick(32'h7FFF_FFFF, 24'hFF_FFFF);
    tick(32'h8000_0000, 24'hFF_FFFF);
    tick(32'h0001_0000, 24'h00_0000);
    tick(32'h000A_0000, 24'h80_0000);
    tick(-32'h000A_0000, 24'h00_0001);
    tick(32'h0064_0000, 24'hFF_FFFF);
    tick(-32'h012C_0000, 24'hFF_FFFF);
    tick(-32'h0190_0000, 24'hFF_FFFF);
    clear_state();
    repeat (5) tick(32'h0003_0000, 24'h01_0000);
    repeat (3) tick(-32'h0002_0000, 24'h01_8000);
    tick(32'h7FFF_FFFF, 24'h00_0000);
    clear_state();
    tick(-32'h0003_0000, 24'h12_3456);
    settle();

    run_phase(DEADBAND_RESET, STEPS_RAD_RESET, MAX_RATE_RESET);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(32'hFFFF_FFFF, 32'h0001_0000, 32'h4000_0000);
    run_phase(32'd655, 32'h0000_0000, MAX_RATE_RESET);
    run_phase(32'd655, STEPS_RAD_RESET, 32'h0000_0000);
    run_phase($urandom() & 32'h00FF_FFFF, $urandom(), $urandom());
    run_phase($urandom_range(0, 65535), $urandom_range(1, 1 << 20),
              $urandom_range(1 << 16, 1 << 28));
    run_phase(DEADBAND_RESET, STEPS_RAD_RESET, MAX_RATE_RESET);

    $display("covered %0d ticks and %0d clears over %0d register settings",
             sb.n_ticks, sb.n_clears, n_settings);
    $display("%0d ticks clamped, %0d issued whole steps, %0d mismatches",
             sb.n_clamped, sb.n_stepped, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("stepper_step_rate_accumulator_core_tb OK");
    end else begin
      $display("stepper_step_rate_accumulator_core_tb NOT OK");
    end
    $finish;
  end

endmodule
